[design/framed_command_parser_assert.svh]
// Assertion macros shared by the parser modules.
`ifndef FRAMED_COMMAND_PARSER_ASSERT_SVH
`define FRAMED_COMMAND_PARSER_ASSERT_SVH

// A property that must hold at every clock edge outside of reset.
`define FCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("framed_command_parser: assertion failed");

// A condition that must never be true outside of reset.
`define FCP_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("framed_command_parser: forbidden condition seen");

`endif

[design/fcp_pkg.sv]
package fcp_pkg;

   localparam int NODE_MAX_BYTES_DEFAULT   = 8;
   localparam int PARAM_INDEX_BITS_DEFAULT = 8;

   localparam int SYMBOL_W = 8;
   localparam int LEN_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [SYMBOL_W-1:0] NEWLINE_BYTE = 8'd10;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_START_CHAR        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_OPEN_CHAR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_CLOSE_CHAR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PARAMS_OPEN_CHAR  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PARAMS_CLOSE_CHAR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPLIT_CHAR        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_NODE_NAME     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OWN_NODE_LEN      = 3'd7;

   localparam logic [SYMBOL_W-1:0] RST_START_CHAR        = 8'd36;
   localparam logic [SYMBOL_W-1:0] RST_HEADER_OPEN_CHAR  = 8'd60;
   localparam logic [SYMBOL_W-1:0] RST_HEADER_CLOSE_CHAR = 8'd62;
   localparam logic [SYMBOL_W-1:0] RST_PARAMS_OPEN_CHAR  = 8'd40;
   localparam logic [SYMBOL_W-1:0] RST_PARAMS_CLOSE_CHAR = 8'd41;
   localparam logic [SYMBOL_W-1:0] RST_SPLIT_CHAR        = 8'd58;
   localparam logic [LEN_W-1:0]    RST_OWN_NODE_LEN      = 4'd0;

   localparam logic [1:0] ST_NOT_READY  = 2'd0;
   localparam logic [1:0] ST_READY      = 2'd1;
   localparam logic [1:0] ST_NOT_FOR_ME = 2'd2;
   localparam logic [1:0] ST_FORMAT     = 2'd3;

   localparam logic [1:0] KIND_NODE    = 2'd0;
   localparam logic [1:0] KIND_COMMAND = 2'd1;
   localparam logic [1:0] KIND_PARAM   = 2'd2;

   localparam logic [1:0] SPLIT_SAT = 2'd2;

   typedef struct packed {
      logic [SYMBOL_W-1:0] start_char;
      logic [SYMBOL_W-1:0] header_open_char;
      logic [SYMBOL_W-1:0] header_close_char;
      logic [SYMBOL_W-1:0] params_open_char;
      logic [SYMBOL_W-1:0] params_close_char;
      logic [SYMBOL_W-1:0] split_char;
      logic [LEN_W-1:0]    own_node_len;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          status;
      logic                payload_valid;
      logic [1:0]          payload_kind;
      logic [7:0]          param_index;
      logic                param_begin;
      logic [SYMBOL_W-1:0] payload_byte;
   } rsp_type;

endpackage

[design/framed_command_parser.sv]
// Channel   Dir  Handshake             Payload
// req_      in   req_tvalid/tready     tdata: symbol
// rsp_      out  rsp_tvalid/tready     tdata: status, param_index, payload_byte
//                                      tuser: payload_valid, payload_kind, param_begin
// csr_      in   csr_valid/csr_ready   csr_index, csr_data
//
// One byte per cycle sustained while the result is taken; an accepted byte waits in the input
// register, then the parse logic writes its result into the result register.
// The per-byte latency is set by those two registers; the parse state updates once per byte.
// Reset is synchronous and clears the frame state and loads the default delimiters.
// A stalled result holds the parse stage; the input register still takes a byte if it is empty.
module framed_command_parser import fcp_pkg::*; #(
   parameter int NODE_MAX_BYTES   = NODE_MAX_BYTES_DEFAULT,
   parameter int PARAM_INDEX_BITS = PARAM_INDEX_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] symbol
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // [1:0] status, [9:2] param_index,
                                              // [17:10] payload_byte, [23:18] zero
   output logic [3:0]            rsp_tuser,   // [0] payload_valid, [2:1] payload_kind,
                                              // [3] param_begin
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

`include "framed_command_parser_assert.svh"

   cfg_type                     cfg;
   logic [8*NODE_MAX_BYTES-1:0] own_name;
   rsp_type                     parse_rsp;

   logic                in_valid_ff, in_valid_in;
   logic [SYMBOL_W-1:0] in_symbol_ff, in_symbol_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                advance;
   logic                req_fire;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   fcp_csr #(
      .NODE_MAX_BYTES(NODE_MAX_BYTES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cfg      (cfg),
      .own_name (own_name)
   );

   fcp_parse #(
      .NODE_MAX_BYTES  (NODE_MAX_BYTES),
      .PARAM_INDEX_BITS(PARAM_INDEX_BITS)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .symbol  (in_symbol_ff),
      .cfg     (cfg),
      .own_name(own_name),
      .rsp     (parse_rsp)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_symbol_in = in_symbol_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_fire) begin
         in_valid_in  = 1'b1;
         in_symbol_in = req_tdata;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = parse_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_symbol_ff <= in_symbol_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.payload_byte, rsp_ff.param_index, rsp_ff.status};
   assign rsp_tuser  = {rsp_ff.param_begin, rsp_ff.payload_kind, rsp_ff.payload_valid};

   `FCP_NEVER(a_no_overrun, clock, reset, req_fire && in_valid_ff && !advance)
   `FCP_ASSERT(a_adv_shows, clock, reset, advance |=> rsp_tvalid)

endmodule

[design/fcp_csr.sv]
module fcp_csr import fcp_pkg::*; #(
   parameter int NODE_MAX_BYTES = NODE_MAX_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   output cfg_type                     cfg,
   output logic [8*NODE_MAX_BYTES-1:0] own_name
);

   localparam int NameW = 8 * NODE_MAX_BYTES;

   cfg_type          cfg_ff, cfg_in;
   logic [NameW-1:0] name_ff, name_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
   assign own_name  = name_ff;

   always_comb begin
      cfg_in  = cfg_ff;
      name_in = name_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_START_CHAR:        cfg_in.start_char        = csr_data[SYMBOL_W-1:0];
            REG_HEADER_OPEN_CHAR:  cfg_in.header_open_char  = csr_data[SYMBOL_W-1:0];
            REG_HEADER_CLOSE_CHAR: cfg_in.header_close_char = csr_data[SYMBOL_W-1:0];
            REG_PARAMS_OPEN_CHAR:  cfg_in.params_open_char  = csr_data[SYMBOL_W-1:0];
            REG_PARAMS_CLOSE_CHAR: cfg_in.params_close_char = csr_data[SYMBOL_W-1:0];
            REG_SPLIT_CHAR:        cfg_in.split_char        = csr_data[SYMBOL_W-1:0];
            // Only the bytes that the name store can hold are kept.
            REG_OWN_NODE_NAME:     name_in                  = csr_data[NameW-1:0];
            REG_OWN_NODE_LEN:      cfg_in.own_node_len      = csr_data[LEN_W-1:0];
            default:               cfg_in                   = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_char        <= RST_START_CHAR;
         cfg_ff.header_open_char  <= RST_HEADER_OPEN_CHAR;
         cfg_ff.header_close_char <= RST_HEADER_CLOSE_CHAR;
         cfg_ff.params_open_char  <= RST_PARAMS_OPEN_CHAR;
         cfg_ff.params_close_char <= RST_PARAMS_CLOSE_CHAR;
         cfg_ff.split_char        <= RST_SPLIT_CHAR;
         cfg_ff.own_node_len      <= RST_OWN_NODE_LEN;
         name_ff                  <= '0;
      end else begin
         cfg_ff  <= cfg_in;
         name_ff <= name_in;
      end
   end

endmodule

[design/fcp_parse.sv]
module fcp_parse import fcp_pkg::*; #(
   parameter int NODE_MAX_BYTES   = NODE_MAX_BYTES_DEFAULT,
   parameter int PARAM_INDEX_BITS = PARAM_INDEX_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [SYMBOL_W-1:0]         symbol,
   input  cfg_type                     cfg,
   input  logic [8*NODE_MAX_BYTES-1:0] own_name,
   output rsp_type                     rsp
);

`include "framed_command_parser_assert.svh"

   localparam int PosW     = $clog2(NODE_MAX_BYTES + 1);
   localparam int SelW     = (NODE_MAX_BYTES > 1) ? $clog2(NODE_MAX_BYTES) : 1;
   localparam int SelDepth = 1 << SelW;
   localparam int CntW     = PARAM_INDEX_BITS + 1;
   localparam int ExtW     = (CntW > 8) ? CntW : 8;
   localparam logic [CntW-1:0] CountLimit = {1'b1, {PARAM_INDEX_BITS{1'b0}}};
   localparam logic [PosW-1:0] PosMax     = PosW'(NODE_MAX_BYTES);

   logic            in_frame_ff, in_frame_in;
   logic            in_header_ff, in_header_in;
   logic            in_params_ff, in_params_in;
   logic [1:0]      split_count_ff, split_count_in;
   logic [PosW-1:0] node_pos_ff, node_pos_in;
   logic            node_mismatch_ff, node_mismatch_in;
   logic [CntW-1:0] param_count_ff, param_count_in;

   logic [SYMBOL_W-1:0] name_bytes [SelDepth];
   logic [SYMBOL_W-1:0] want_byte;
   logic                pos_lt_max;
   logic                name_hit;
   logic [CntW-1:0]     count_inc;
   logic [CntW-1:0]     idx_new;
   logic [CntW-1:0]     idx_cur;
   logic [ExtW-1:0]     idx_new_ext;
   logic [ExtW-1:0]     idx_cur_ext;

   always_comb begin
      for (int i = 0; i < SelDepth; i++) begin
         name_bytes[i] = '0;
      end
      for (int i = 0; i < NODE_MAX_BYTES; i++) begin
         name_bytes[i] = own_name[8*i +: 8];
      end
   end

   assign want_byte  = name_bytes[node_pos_ff[SelW-1:0]];
   assign pos_lt_max = node_pos_ff < PosMax;
   assign name_hit   = pos_lt_max && (LEN_W'(node_pos_ff) < cfg.own_node_len)
                       && (want_byte == symbol);

   // Parameter count saturates one above the largest index.
   assign count_inc   = (param_count_ff < CountLimit) ? param_count_ff + 1'b1
                                                      : param_count_ff;
   assign idx_new     = count_inc - 1'b1;
   assign idx_cur     = (param_count_ff == '0) ? '0 : param_count_ff - 1'b1;
   assign idx_new_ext = ExtW'(idx_new);
   assign idx_cur_ext = ExtW'(idx_cur);

   always_comb begin
      logic err;
      logic drop;
      err              = 1'b0;
      drop             = 1'b0;
      in_frame_in      = in_frame_ff;
      in_header_in     = in_header_ff;
      in_params_in     = in_params_ff;
      split_count_in   = split_count_ff;
      node_pos_in      = node_pos_ff;
      node_mismatch_in = node_mismatch_ff;
      param_count_in   = param_count_ff;
      rsp              = '0;

      if (symbol == NEWLINE_BYTE && in_frame_ff) begin
         err = 1'b1;
      end else if (symbol == cfg.start_char) begin
         if (in_frame_ff) begin
            in_frame_in = 1'b0;
            if (in_params_ff || split_count_ff == 2'd0) begin
               err = 1'b1;
            end else begin
               rsp.status = ST_READY;
            end
         end else begin
            drop        = 1'b1;
            in_frame_in = 1'b1;
         end
      end else if (in_frame_ff) begin
         if (symbol == cfg.header_open_char) begin
            if (in_params_ff) begin
               err = 1'b1;
            end else begin
               in_header_in = 1'b1;
            end
         end else if (symbol == cfg.header_close_char) begin
            if (!in_header_ff || split_count_ff != 2'd1) begin
               err = 1'b1;
            end else begin
               in_header_in = 1'b0;
            end
         end else if (symbol == cfg.params_open_char) begin
            if (in_header_ff) begin
               err = 1'b1;
            end else begin
               in_params_in     = 1'b1;
               param_count_in   = count_inc;
               rsp.param_begin  = 1'b1;
               rsp.payload_kind = KIND_PARAM;
               rsp.param_index  = idx_new_ext[7:0];
            end
         end else if (symbol == cfg.params_close_char) begin
            if (!in_params_ff) begin
               err = 1'b1;
            end else begin
               in_params_in = 1'b0;
            end
         end else if (symbol == cfg.split_char) begin
            if (split_count_ff < SPLIT_SAT) begin
               split_count_in = split_count_ff + 2'd1;
            end
            if (in_params_ff) begin
               param_count_in   = count_inc;
               rsp.param_begin  = 1'b1;
               rsp.payload_kind = KIND_PARAM;
               rsp.param_index  = idx_new_ext[7:0];
            end else if (!in_header_ff) begin
               err = 1'b1;
            end else if (node_mismatch_ff || LEN_W'(node_pos_ff) != cfg.own_node_len) begin
               // The header splitter ends the node name: a frame for another node.
               drop       = 1'b1;
               rsp.status = ST_NOT_FOR_ME;
            end
         end else if (in_header_ff) begin
            rsp.payload_valid = 1'b1;
            rsp.payload_byte  = symbol;
            if (split_count_ff == 2'd0) begin
               rsp.payload_kind = KIND_NODE;
               if (!name_hit) begin
                  node_mismatch_in = 1'b1;
               end
               if (pos_lt_max) begin
                  node_pos_in = node_pos_ff + 1'b1;
               end
            end else begin
               rsp.payload_kind = KIND_COMMAND;
            end
         end else if (in_params_ff) begin
            rsp.payload_valid = 1'b1;
            rsp.payload_byte  = symbol;
            rsp.payload_kind  = KIND_PARAM;
            rsp.param_index   = idx_cur_ext[7:0];
         end
      end

      if (err) begin
         drop       = 1'b1;
         rsp        = '0;
         rsp.status = ST_FORMAT;
      end

      // Dropping a frame clears everything; a start byte then reopens it.
      if (drop) begin
         in_frame_in      = in_frame_in && !err && (rsp.status != ST_NOT_FOR_ME);
         in_header_in     = 1'b0;
         in_params_in     = 1'b0;
         split_count_in   = '0;
         node_pos_in      = '0;
         node_mismatch_in = 1'b0;
         param_count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff      <= 1'b0;
         in_header_ff     <= 1'b0;
         in_params_ff     <= 1'b0;
         split_count_ff   <= '0;
         node_pos_ff      <= '0;
         node_mismatch_ff <= 1'b0;
         param_count_ff   <= '0;
      end else if (fire) begin
         in_frame_ff      <= in_frame_in;
         in_header_ff     <= in_header_in;
         in_params_ff     <= in_params_in;
         split_count_ff   <= split_count_in;
         node_pos_ff      <= node_pos_in;
         node_mismatch_ff <= node_mismatch_in;
         param_count_ff   <= param_count_in;
      end
   end

   `FCP_NEVER(a_split_sat, clock, reset, split_count_ff > SPLIT_SAT)
   `FCP_ASSERT(a_count_sat, clock, reset, param_count_ff <= CountLimit)
   `FCP_ASSERT(a_err_clean, clock, reset,
      (fire && rsp.status == ST_FORMAT) |=> (param_count_ff == '0 && !in_frame_ff))

endmodule
